// ----- src/polyval_pkg.sv -----
// ============================================================================
// polyval_pkg - shared types and constants for the POLYVAL hash
// Field width, digit size, reduction constant, register indexes and the
// controller state encoding.
// ============================================================================
`default_nettype none

package polyval_pkg;

	// Field element and digit geometry
	localparam int BLOCK_W    = 128;
	localparam int HALF_W     = 64;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = BLOCK_W / DIGIT_W;
	localparam int CNT_W      = $clog2(NUM_DIGITS);

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [HALF_W-1:0]  half_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CNT_W-1:0]   digit_cnt_t;

	// x^128 + x^127 + x^126 + x^121 + 1 divided by x, without the constant term:
	// what is folded in when a set low bit is shifted out
	localparam block_t POLY_RED = {8'hE1, 120'd0};

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LO   = 3'd0,
		CFG_KEY_HI   = 3'd1,
		CFG_SEED_LO  = 3'd2,
		CFG_SEED_HI  = 3'd3,
		CFG_USE_SEED = 3'd4
	} cfg_idx_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

endpackage

`default_nettype wire

// ----- src/polyval_mul.sv -----
// ============================================================================
// polyval_mul - digit-serial POLYVAL field multiplier
// Computes a * b * x^-128 mod P, one 8-bit digit of a per cycle, LSB first,
// with a Montgomery right shift after every bit.
// ============================================================================
`default_nettype none

module polyval_mul (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire [polyval_pkg::BLOCK_W-1:0]     a,
	input  wire [polyval_pkg::BLOCK_W-1:0]     b,
	output logic                               done,
	output polyval_pkg::block_t                result
);

	polyval_pkg::block_t     a_q;
	polyval_pkg::block_t     r_q;
	polyval_pkg::digit_cnt_t cnt_q;
	logic                    busy_q;
	logic                    done_q;
	polyval_pkg::block_t     r_next;

	// One digit: add b for each set bit, then divide by x modulo P
	function automatic polyval_pkg::block_t digit_step(
		input polyval_pkg::block_t r,
		input polyval_pkg::block_t bb,
		input polyval_pkg::digit_t d
	);
		polyval_pkg::block_t acc;
		logic                m;
		acc = r;
		for (int i = 0; i < polyval_pkg::DIGIT_W; i++) begin
			if (d[i]) begin
				acc = acc ^ bb;
			end
			m   = acc[0];
			acc = acc >> 1;
			if (m) begin
				acc = acc ^ polyval_pkg::POLY_RED;
			end
		end
		return acc;
	endfunction

	assign r_next = digit_step(r_q, b, a_q[polyval_pkg::DIGIT_W-1:0]);

	// Control: count digits, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == polyval_pkg::digit_cnt_t'(polyval_pkg::NUM_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operand, then shift one digit out per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q >> polyval_pkg::DIGIT_W;
			r_q <= r_next;
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

`default_nettype wire

// ----- src/polyval_universal_hash_top.sv -----
// ============================================================================
// polyval_universal_hash_top - POLYVAL universal hash, one block per transfer
// Accumulates S = dot(S xor block, H) and emits S with the last block.
// ============================================================================
// Each 128-bit block passes, from its transfer until the next block can be
// taken, through loading the multiplier, the 8-bit digit-serial field
// multiplier (one digit of S xor block per cycle), and writing the
// accumulator back. The accumulator feeds the next block, so blocks are
// processed one at a time. A tag sits in the output register until taken;
// the next block is accepted meanwhile, and only a second tag finishing
// while the first is still stalled holds the block. Key, seed and use_seed
// must be written through the configuration port only while no block is in
// flight; the block itself does not enforce this. cfg_ready is always high.
`default_nettype none

module polyval_universal_hash_top (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration write channel
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [polyval_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [polyval_pkg::HALF_W-1:0]  cfg_data,
	// block input channel
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire [polyval_pkg::HALF_W-1:0]  block_lo,
	input  wire [polyval_pkg::HALF_W-1:0]  block_hi,
	input  wire                            first_block,
	input  wire                            last_block,
	// tag output channel
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [polyval_pkg::HALF_W-1:0] tag_lo,
	output logic [polyval_pkg::HALF_W-1:0] tag_hi
);

	polyval_pkg::half_t  key_lo_q, key_hi_q, seed_lo_q, seed_hi_q;
	logic                use_seed_q;
	polyval_pkg::block_t acc_q;
	polyval_pkg::block_t tag_q;
	logic                out_valid_q;
	logic                last_q;
	polyval_pkg::state_t state_q, state_d;

	logic                in_xfer;
	logic                out_free;
	logic                load_tag;
	polyval_pkg::block_t tag_src;
	polyval_pkg::block_t start_val;
	polyval_pkg::block_t mul_a;
	logic                mul_done;
	polyval_pkg::block_t mul_res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q   <= '0;
			key_hi_q   <= '0;
			seed_lo_q  <= '0;
			seed_hi_q  <= '0;
			use_seed_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				polyval_pkg::CFG_KEY_LO:   key_lo_q   <= cfg_data;
				polyval_pkg::CFG_KEY_HI:   key_hi_q   <= cfg_data;
				polyval_pkg::CFG_SEED_LO:  seed_lo_q  <= cfg_data;
				polyval_pkg::CFG_SEED_HI:  seed_hi_q  <= cfg_data;
				polyval_pkg::CFG_USE_SEED: use_seed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pick the starting value and form the multiplier operand
	assign in_xfer = in_valid && !in_stall;

	always_comb begin
		if (first_block) begin
			start_val = use_seed_q ? {seed_hi_q, seed_lo_q} : '0;
		end else begin
			start_val = acc_q;
		end
		mul_a = start_val ^ {block_hi, block_lo};
	end

	polyval_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.a      (mul_a),
		.b      ({key_hi_q, key_lo_q}),
		.done   (mul_done),
		.result (mul_res)
	);

	// Output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer: next state and outputs
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		load_tag = 1'b0;
		tag_src  = mul_res;
		unique case (state_q)
			polyval_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = polyval_pkg::ST_RUN;
				end
			end
			polyval_pkg::ST_RUN: begin
				if (mul_done) begin
					if (!last_q) begin
						state_d = polyval_pkg::ST_IDLE;
					end else if (out_free) begin
						load_tag = 1'b1;
						state_d  = polyval_pkg::ST_IDLE;
					end else begin
						state_d = polyval_pkg::ST_HOLD;
					end
				end
			end
			polyval_pkg::ST_HOLD: begin
				tag_src = acc_q;
				if (out_free) begin
					load_tag = 1'b1;
					state_d  = polyval_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = polyval_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= polyval_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Accumulator and last-block flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				last_q <= last_block;
			end
			if (state_q == polyval_pkg::ST_RUN && mul_done) begin
				acc_q <= mul_res;
			end
		end
	end

	// Output register: load a tag, drop valid once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_tag) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_tag) begin
			tag_q <= tag_src;
		end
	end

	assign out_valid = out_valid_q;
	assign tag_lo    = tag_q[polyval_pkg::HALF_W-1:0];
	assign tag_hi    = tag_q[polyval_pkg::BLOCK_W-1:polyval_pkg::HALF_W];

endmodule

`default_nettype wire

// ----- tb/tb_polyval_universal_hash_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_polyval_universal_hash_top - self-checking bench for the POLYVAL hash
// Drives message blocks and register writes, predicts every tag with its own
// GF(2^128) dot product, and checks each tag transfer field by field.
// ============================================================================
`default_nettype none

module tb_polyval_universal_hash_top;

	localparam int                 CFG_NUM_REGS  = 5;
	localparam polyval_pkg::half_t RED_WORD      = 64'hC200_0000_0000_0000;
	localparam polyval_pkg::half_t HALF_MSB      = 64'h8000_0000_0000_0000;
	localparam polyval_pkg::half_t HALF_ONE      = 64'h1;
	localparam int                 SETTLE_CYCLES = 40;
	localparam int                 LIMIT_CYCLES  = 1_000_000;
	localparam int                 RANDOM_ITEMS  = 600;
	localparam int                 RESEED_EVERY  = 150;

	typedef logic [polyval_pkg::CFG_IDX_W-1:0] reg_index_t;

	typedef struct packed {
		polyval_pkg::half_t lo;
		polyval_pkg::half_t hi;
	} tag_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	reg_index_t           cfg_index   = '0;
	polyval_pkg::half_t   cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	polyval_pkg::half_t   block_lo    = '0;
	polyval_pkg::half_t   block_hi    = '0;
	logic                 first_block = 1'b0;
	logic                 last_block  = 1'b0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	polyval_pkg::half_t   tag_lo;
	polyval_pkg::half_t   tag_hi;

	// predictor copy of configuration and running sum
	polyval_pkg::block_t hash_key;
	polyval_pkg::block_t seed_tag;
	logic                seed_mode;
	polyval_pkg::block_t running_sum;

	tag_t pending_tags[$];
	int   errors        = 0;
	int   cycle_count   = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;

	polyval_universal_hash_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.block_lo    (block_lo),
		.block_hi    (block_hi),
		.first_block (first_block),
		.last_block  (last_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tag_lo      (tag_lo),
		.tag_hi      (tag_hi)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// 64x64 carry-less product
	function automatic polyval_pkg::block_t clmul_half(polyval_pkg::half_t a,
			polyval_pkg::half_t b);
		polyval_pkg::block_t prod;
		prod = '0;
		for (int i = 0; i < polyval_pkg::HALF_W; i++) begin
			if (b[i])
				prod ^= polyval_pkg::block_t'(a) << i;
		end
		return prod;
	endfunction

	// a*b*x^-128 in the POLYVAL field, folded twice with the reduction word
	function automatic polyval_pkg::block_t gf_dot(polyval_pkg::block_t a,
			polyval_pkg::block_t b);
		polyval_pkg::block_t lo_prod, hi_prod, mid_prod, fold;
		polyval_pkg::half_t  w0, w1, w2, w3, f0, f1, g0, g1;
		lo_prod  = clmul_half(a[63:0], b[63:0]);
		hi_prod  = clmul_half(a[127:64], b[127:64]);
		mid_prod = clmul_half(a[63:0], b[127:64]) ^ clmul_half(a[127:64], b[63:0]);
		w0 = lo_prod[63:0];
		w1 = lo_prod[127:64] ^ mid_prod[63:0];
		w2 = hi_prod[63:0] ^ mid_prod[127:64];
		w3 = hi_prod[127:64];
		fold = clmul_half(w0, RED_WORD);
		f0   = fold[63:0] ^ w1;
		f1   = fold[127:64] ^ w0;
		fold = clmul_half(f0, RED_WORD);
		g0   = f1 ^ fold[63:0];
		g1   = f0 ^ fold[127:64];
		return {g1 ^ w3, g0 ^ w2};
	endfunction

	// advance the running sum by one block; queue the tag on a message end
	function automatic void hash_absorb(polyval_pkg::half_t lo, polyval_pkg::half_t hi,
			logic is_first, logic is_last);
		polyval_pkg::block_t start;
		tag_t                tag;
		start = running_sum;
		if (is_first)
			start = seed_mode ? seed_tag : '0;
		running_sum = gf_dot(start ^ {hi, lo}, hash_key);
		if (is_last) begin
			tag.lo = running_sum[63:0];
			tag.hi = running_sum[127:64];
			pending_tags.push_back(tag);
		end
	endfunction

	function automatic polyval_pkg::half_t rand_half();
		return {$urandom, $urandom};
	endfunction

	// drive the receiver stall
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_idle_pct);
	end

	// check each tag transfer against the oldest prediction
	always @(posedge clk) begin : check_tags
		tag_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tags.size() == 0) begin
				$display("%0t: unexpected tag: expected none, actual lo=%h hi=%h",
					$time, tag_lo, tag_hi);
				errors++;
			end else begin
				want = pending_tags.pop_front();
				if (tag_lo !== want.lo) begin
					$display("%0t: tag_lo mismatch: expected %h, actual %h",
						$time, want.lo, tag_lo);
					errors++;
				end
				if (tag_hi !== want.hi) begin
					$display("%0t: tag_hi mismatch: expected %h, actual %h",
						$time, want.hi, tag_hi);
					errors++;
				end
			end
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d tags outstanding", $time, pending_tags.size());
			$display("tb: failure");
			$finish;
		end
	end

	// one register write transfer
	task automatic write_reg(reg_index_t idx, polyval_pkg::half_t data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			polyval_pkg::CFG_KEY_LO:   hash_key[63:0]   = data;
			polyval_pkg::CFG_KEY_HI:   hash_key[127:64] = data;
			polyval_pkg::CFG_SEED_LO:  seed_tag[63:0]   = data;
			polyval_pkg::CFG_SEED_HI:  seed_tag[127:64] = data;
			polyval_pkg::CFG_USE_SEED: seed_mode        = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one block transfer, with random idle cycles ahead of it
	task automatic send_block(polyval_pkg::half_t lo, polyval_pkg::half_t hi,
			logic is_first, logic is_last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		block_lo    = lo;
		block_hi    = hi;
		first_block = is_first;
		last_block  = is_last;
		in_valid    = 1'b1;
		do @(posedge clk); while (in_stall);
		hash_absorb(lo, hi, is_first, is_last);
	endtask

	// hold off until every tag is back and the last block has left the multiplier
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key(polyval_pkg::block_t key);
		write_reg(polyval_pkg::CFG_KEY_LO, key[63:0]);
		write_reg(polyval_pkg::CFG_KEY_HI, key[127:64]);
	endtask

	task automatic set_seed(polyval_pkg::block_t seed, polyval_pkg::half_t mode_word);
		write_reg(polyval_pkg::CFG_SEED_LO, seed[63:0]);
		write_reg(polyval_pkg::CFG_SEED_HI, seed[127:64]);
		write_reg(polyval_pkg::CFG_USE_SEED, mode_word);
	endtask

	// non-start blocks right after reset chain from a zero sum
	task automatic test_reset_chaining();
		send_block(rand_half(), rand_half(), 1'b0, 1'b1);
		wait_idle();
	endtask

	// single-block messages at the extremes of block and key
	task automatic test_field_extremes();
		set_key({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		send_block('0, '0, 1'b1, 1'b1);
		send_block('1, '1, 1'b1, 1'b1);
		send_block(HALF_ONE, '0, 1'b1, 1'b1);
		send_block('0, HALF_MSB, 1'b1, 1'b1);
		wait_idle();
		set_key({64'h0, HALF_ONE});
		send_block(rand_half(), rand_half(), 1'b1, 1'b1);
		wait_idle();
		set_key({HALF_MSB, 64'h0});
		send_block(rand_half(), rand_half(), 1'b1, 1'b1);
		wait_idle();
	endtask

	// multi-block messages and blocks chaining past a finished tag
	task automatic test_multi_block();
		set_key({rand_half(), rand_half()});
		send_block(rand_half(), rand_half(), 1'b1, 1'b0);
		send_block(rand_half(), rand_half(), 1'b0, 1'b0);
		send_block(rand_half(), rand_half(), 1'b0, 1'b1);
		send_block(rand_half(), rand_half(), 1'b0, 1'b1);
		send_block(rand_half(), rand_half(), 1'b0, 1'b0);
		send_block(rand_half(), rand_half(), 1'b0, 1'b1);
		wait_idle();
	endtask

	// messages continuing from a seed tag, mode taken from bit 0 only
	task automatic test_seed_mode();
		set_seed({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, '1);
		send_block('0, '0, 1'b1, 1'b1);
		send_block(rand_half(), rand_half(), 1'b1, 1'b0);
		send_block(rand_half(), rand_half(), 1'b0, 1'b1);
		wait_idle();
		set_seed({rand_half(), 64'h0}, HALF_ONE);
		send_block(rand_half(), rand_half(), 1'b1, 1'b1);
		wait_idle();
		write_reg(polyval_pkg::CFG_USE_SEED, 64'hFFFF_FFFF_FFFF_FFFE);
		send_block(rand_half(), rand_half(), 1'b1, 1'b1);
		wait_idle();
	endtask

	// writes to unused register indexes change nothing
	task automatic test_register_corners();
		for (int idx = CFG_NUM_REGS; idx < 2 ** polyval_pkg::CFG_IDX_W; idx++)
			write_reg(reg_index_t'(idx), '1);
		send_block(rand_half(), rand_half(), 1'b1, 1'b1);
		wait_idle();
	endtask

	// draw a new key, seed and mode, sometimes at the extremes
	task automatic reseed_settings();
		polyval_pkg::block_t key;
		key = {rand_half(), rand_half()};
		case ($urandom_range(5))
			0: key = '0;
			1: key = '1;
			default: ;
		endcase
		set_key(key);
		set_seed({rand_half(), rand_half()}, rand_half());
		if ($urandom_range(3) == 0)
			write_reg(reg_index_t'($urandom_range(2 ** polyval_pkg::CFG_IDX_W - 1,
				CFG_NUM_REGS)), rand_half());
	endtask

	// mostly well-formed messages with random content, some loose blocks
	task automatic test_random_traffic(int send_pct, int recv_pct);
		int sent;
		int msg_len;
		int reseeds;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent    = 0;
		reseeds = 0;
		while (sent < RANDOM_ITEMS) begin
			// new settings every RESEED_EVERY blocks, with nothing in flight
			if (sent >= reseeds * RESEED_EVERY) begin
				wait_idle();
				reseed_settings();
				reseeds++;
			end
			if ($urandom_range(9) == 0) begin
				send_block(rand_half(), rand_half(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				msg_len = ($urandom_range(3) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
				for (int k = 0; k < msg_len; k++)
					send_block(rand_half(), rand_half(), k == 0, k == msg_len - 1);
				sent += msg_len;
			end
		end
		wait_idle();
	endtask

	initial begin
		hash_key    = '0;
		seed_tag    = '0;
		seed_mode   = 1'b0;
		running_sum = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_chaining();
		test_field_extremes();
		test_multi_block();
		test_seed_mode();
		test_register_corners();
		test_random_traffic(14, 78);
		test_random_traffic(78, 14);
		test_random_traffic(0, 0);

		if (errors == 0 && pending_tags.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
